/* rtl/core/ipv4p_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and character codes for the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

   // Parse phase of the current string
   typedef enum logic [2:0] {
      PH_START,   // expecting the first digit of a part
      PH_ZERO,    // part began with a '0'
      PH_DIGIT,   // inside the digits of a part
      PH_DONE,    // whitespace seen, address settled
      PH_FAIL     // malformed, wait for the terminator
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_D0    = 8'h30;
   localparam logic [7:0] CH_D9    = 8'h39;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_   = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;

   // Range limits for the last part, by number of earlier parts
   localparam logic [31:0] LIMIT_24 = 32'h00FF_FFFF;
   localparam logic [31:0] LIMIT_16 = 32'h0000_FFFF;
   localparam logic [31:0] LIMIT_8  = 32'h0000_00FF;

   localparam int unsigned NUM_EARLIER = 3;

   // Complete parser state
   typedef struct packed {
      phase_type                     phase;
      logic [31:0]                   accum;
      radix_type                     radix;
      logic [1:0]                    part_count;
      logic [NUM_EARLIER-1:0][7:0]   parts;
      logic [NUM_EARLIER-1:0]        too_big;
   } parse_state_type;

   // Result of one character step
   typedef struct packed {
      logic        emit;
      logic        ok;
      logic [31:0] address;
   } step_result_type;

endpackage

/* rtl/core/ipv4_dotted_address_parser.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser
// Streaming inet_aton style IPv4 address parser, one character per word.
//
// Feed the string one character per word on the req_ channel, ending with a
// NUL. Parts may be decimal, octal (leading 0) or hex (leading 0x); one to
// four parts are accepted. On each NUL one rsp_ word is returned with
// rsp_valid_res and the address (first of two or more parts in bits 31:24),
// or all ones if the string was malformed; the parser then starts over. One
// character is taken every cycle while req_stall is low. A NUL accepted into
// the input register is parsed out of it and loads the result register,
// which drives rsp_valid and holds the word until it is taken.
// req_stall rises only when a NUL sits in the input register while the result
// register still holds a stalled word.
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   // parse result
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [31:0] rsp_address
);

   logic                        in_valid_ff;
   logic [7:0]                  in_ch_ff;
   ipv4p_pkg::parse_state_type  state_ff;
   ipv4p_pkg::parse_state_type  state_in;
   ipv4p_pkg::step_result_type  step_res;
   logic                        out_valid_ff;
   logic                        out_ok_ff;
   logic [31:0]                 out_addr_ff;
   logic                        out_free;
   logic                        advance;

   ipv4p_step u_step (
      .cur    (state_ff),
      .ch     (in_ch_ff),
      .nxt    (state_in),
      .result (step_res)
   );

   // Input word may move on unless it produces a result the output can't take
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!step_res.emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_ch_ff <= req_ch;
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= ipv4p_pkg::PH_START;
         state_ff.accum      <= '0;
         state_ff.radix      <= ipv4p_pkg::RADIX_DEC;
         state_ff.part_count <= '0;
         state_ff.parts      <= '0;
         state_ff.too_big    <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_res.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && step_res.emit) begin
         out_ok_ff   <= step_res.ok;
         out_addr_ff <= step_res.address;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = out_ok_ff;
   assign rsp_address   = out_addr_ff;

   // A failed parse always reports all ones
   a_fail_all_ones : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_address == 32'hFFFF_FFFF))
      else $error("failed parse without all-ones address");

   // Input only backs up behind a stalled result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && in_valid_ff))
      else $error("input stalled without a blocked result");

   // Failure is sticky until the terminator
   a_fail_sticky : assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ch_ff != ipv4p_pkg::CH_NUL) &&
       (state_ff.phase == ipv4p_pkg::PH_FAIL)) |=> (state_ff.phase == ipv4p_pkg::PH_FAIL))
      else $error("parser left the failed phase before NUL");

   // A terminator always rearms the parser
   a_rearm : assert property (@(posedge clock) disable iff (reset)
      (advance && (in_ch_ff == ipv4p_pkg::CH_NUL)) |=>
         (state_ff.phase == ipv4p_pkg::PH_START) && (state_ff.part_count == 2'd0))
      else $error("parser not rearmed after NUL");

endmodule

/* rtl/core/ipv4p_step.sv */
// ----------------------------------------------------------------------------
// ipv4p_step
// Combinational parse step: given the parser state and one character,
// produces the next state and, on a NUL, the finished address.
// ----------------------------------------------------------------------------
module ipv4p_step (
   input  ipv4p_pkg::parse_state_type  cur,
   input  logic [7:0]                  ch,
   output ipv4p_pkg::parse_state_type  nxt,
   output ipv4p_pkg::step_result_type  result
);

   logic        ch_dec;
   logic        ch_ws;
   logic        ch_hex_letter;
   logic [3:0]  digit_val;
   logic [3:0]  hex_val;
   logic [31:0] mul_accum;
   logic        asm_ok;
   logic [31:0] asm_addr;

   // Character classes
   always_comb begin
      ch_dec        = (ch >= ipv4p_pkg::CH_D0) && (ch <= ipv4p_pkg::CH_D9);
      ch_ws         = (ch == ipv4p_pkg::CH_SPACE) ||
                      ((ch >= ipv4p_pkg::CH_TAB) && (ch <= ipv4p_pkg::CH_CR));
      digit_val     = ch[3:0];
      ch_hex_letter = ((ch >= ipv4p_pkg::CH_LA) && (ch <= ipv4p_pkg::CH_LF_)) ||
                      ((ch >= ipv4p_pkg::CH_UA) && (ch <= ipv4p_pkg::CH_UF));
      // 'a'..'f' and 'A'..'F' have low nibble 1..6
      hex_val       = ch[3:0] + 4'd9;
   end

   // accum * radix from shifts and at most one add (digit added below)
   always_comb begin
      case (cur.radix)
         ipv4p_pkg::RADIX_HEX: mul_accum = {cur.accum[27:0], 4'b0000};
         ipv4p_pkg::RADIX_OCT: mul_accum = {cur.accum[28:0], 3'b000};
         default:              mul_accum = {cur.accum[28:0], 3'b000} +
                                           {cur.accum[30:0], 1'b0};
      endcase
   end

   // Address assembly from the closed parts and the current value
   always_comb begin
      case (cur.part_count)
         2'd0: begin
            asm_ok   = 1'b1;
            asm_addr = cur.accum;
         end
         2'd1: begin
            asm_ok   = (cur.accum <= ipv4p_pkg::LIMIT_24) && !cur.too_big[0];
            asm_addr = cur.accum | {cur.parts[0], 24'd0};
         end
         2'd2: begin
            asm_ok   = (cur.accum <= ipv4p_pkg::LIMIT_16) && (cur.too_big[1:0] == 2'b00);
            asm_addr = cur.accum | {cur.parts[0], cur.parts[1], 16'd0};
         end
         default: begin
            asm_ok   = (cur.accum <= ipv4p_pkg::LIMIT_8) && (cur.too_big == 3'b000);
            asm_addr = cur.accum | {cur.parts[0], cur.parts[1], cur.parts[2], 8'd0};
         end
      endcase
   end

   // Next state
   always_comb begin
      nxt = cur;
      if (ch == ipv4p_pkg::CH_NUL) begin
         nxt.phase      = ipv4p_pkg::PH_START;
         nxt.accum      = '0;
         nxt.radix      = ipv4p_pkg::RADIX_DEC;
         nxt.part_count = '0;
         nxt.parts      = '0;
         nxt.too_big    = '0;
      end else begin
         case (cur.phase)
            ipv4p_pkg::PH_START: begin
               if (!ch_dec) begin
                  nxt.phase = ipv4p_pkg::PH_FAIL;
               end else if (ch == ipv4p_pkg::CH_D0) begin
                  nxt.accum = '0;
                  nxt.radix = ipv4p_pkg::RADIX_OCT;
                  nxt.phase = ipv4p_pkg::PH_ZERO;
               end else begin
                  nxt.accum = {28'd0, digit_val};
                  nxt.radix = ipv4p_pkg::RADIX_DEC;
                  nxt.phase = ipv4p_pkg::PH_DIGIT;
               end
            end
            ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGIT: begin
               nxt.phase = ipv4p_pkg::PH_DIGIT;
               if ((cur.phase == ipv4p_pkg::PH_ZERO) &&
                   ((ch == ipv4p_pkg::CH_LX) || (ch == ipv4p_pkg::CH_UX))) begin
                  nxt.radix = ipv4p_pkg::RADIX_HEX;
               end else if (ch_dec) begin
                  // in the zero phase radix is octal, so this is accum*8
                  nxt.accum = mul_accum + {28'd0, digit_val};
               end else if ((cur.phase == ipv4p_pkg::PH_DIGIT) &&
                            (cur.radix == ipv4p_pkg::RADIX_HEX) && ch_hex_letter) begin
                  nxt.accum = {cur.accum[27:0], hex_val};
               end else if (ch == ipv4p_pkg::CH_DOT) begin
                  // close a part
                  if (cur.part_count == 2'd3) begin
                     nxt.phase = ipv4p_pkg::PH_FAIL;
                  end else begin
                     for (int i = 0; i < ipv4p_pkg::NUM_EARLIER; i++) begin
                        if (cur.part_count == 2'(i)) begin
                           nxt.parts[i]   = cur.accum[7:0];
                           nxt.too_big[i] = cur.too_big[i] | (cur.accum > 32'd255);
                        end
                     end
                     nxt.part_count = cur.part_count + 2'd1;
                     nxt.accum      = '0;
                     nxt.radix      = ipv4p_pkg::RADIX_DEC;
                     nxt.phase      = ipv4p_pkg::PH_START;
                  end
               end else if (ch_ws) begin
                  if (asm_ok) begin
                     nxt.accum = asm_addr;
                     nxt.phase = ipv4p_pkg::PH_DONE;
                  end else begin
                     nxt.phase = ipv4p_pkg::PH_FAIL;
                  end
               end else begin
                  nxt.phase = ipv4p_pkg::PH_FAIL;
               end
            end
            ipv4p_pkg::PH_DONE: begin
               nxt.phase = ipv4p_pkg::PH_DONE;
            end
            default: begin
               nxt.phase = ipv4p_pkg::PH_FAIL;
            end
         endcase
      end
   end

   // Result on the terminator
   always_comb begin
      result.emit = (ch == ipv4p_pkg::CH_NUL);
      case (cur.phase)
         ipv4p_pkg::PH_DONE:                      result.ok = 1'b1;
         ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGIT: result.ok = asm_ok;
         default:                                 result.ok = 1'b0;
      endcase
      if (!result.ok) begin
         result.address = '1;
      end else if (cur.phase == ipv4p_pkg::PH_DONE) begin
         result.address = cur.accum;
      end else begin
         result.address = asm_addr;
      end
   end

endmodule
